FILE: rtl/gb5_pkg.sv
// ----------------------------------------------------------------------------
// gb5_pkg
// Shared types, constants and kernel weights of the 5x5 Gaussian blur.
// ----------------------------------------------------------------------------
package gb5_pkg;

  localparam int PIX_W       = 24;
  localparam int NTAP        = 5;
  localparam int NSLOT       = 4;
  localparam int NCH         = 3;
  localparam int PART_W      = 15;
  localparam int SUM_W       = 17;
  localparam int PROD_W      = 34;
  localparam int RECIP_SHIFT = 25;

  // ceil(2^25 / 273); exact truncating divide for sums below 273 * 256
  localparam logic [SUM_W-1:0] RECIP = 17'd122911;

  localparam logic [11:0] WIDTH_RST  = 12'd640;
  localparam logic [11:0] HEIGHT_RST = 12'd480;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef logic [PIX_W-1:0]                 pix_t;
  typedef logic [NTAP-1:0][PIX_W-1:0]       pix_col_t;
  typedef logic [NSLOT-1:0][PIX_W-1:0]      slot_row_t;
  typedef logic [NCH-1:0][PART_W-1:0]       part_t;
  typedef logic [NTAP-1:0][NCH-1:0][PART_W-1:0] part_row_t;
  typedef logic [NCH-1:0][7:0]              chan_t;

  typedef struct packed {
    logic shift;
    logic calc;
  } cell_ctl_t;

  typedef struct packed {
    logic ld_sum;
    logic ld_prod;
  } div_ctl_t;

  typedef struct packed {
    logic [10:0] ccol;
    logic [11:0] crow;
  } pos_t;

  // kernel weight at window column c, row r (0..4)
  function automatic logic [5:0] gb5_weight(input logic [2:0] c, input logic [2:0] r);
    logic [1:0] dc;
    logic [1:0] dr;
    logic [5:0] w;
    dc = (c >= 3'd2) ? 2'(c - 3'd2) : 2'(3'd2 - c);
    dr = (r >= 3'd2) ? 2'(r - 3'd2) : 2'(3'd2 - r);
    case ({dc, dr})
      4'b0000:          w = 6'd41;
      4'b0001, 4'b0100: w = 6'd26;
      4'b0010, 4'b1000: w = 6'd7;
      4'b0101:          w = 6'd16;
      4'b0110, 4'b1001: w = 6'd4;
      4'b1010:          w = 6'd1;
      default:          w = 6'd0;
    endcase
    return w;
  endfunction

endpackage

FILE: rtl/gb5_cell.sv
// ----------------------------------------------------------------------------
// gb5_cell
// One window column: holds five pixels, passes them left on each shift and
// registers its weighted column sum per channel.
// ----------------------------------------------------------------------------
module gb5_cell import gb5_pkg::*; #(
  parameter int POS = 0
) (
  input  logic      clk_i,
  input  cell_ctl_t ctl_i,
  input  pix_col_t  col_i,
  output pix_col_t  col_o,
  output part_t     part_o
);

  pix_col_t col_q;
  part_t    part_q;
  part_t    part_d;

  always_comb begin
    part_d = '0;
    for (int ch = 0; ch < NCH; ch++) begin
      for (int r = 0; r < NTAP; r++) begin
        part_d[ch] = part_d[ch]
                   + PART_W'(gb5_weight(3'(POS), 3'(r))) * PART_W'(col_q[r][8*ch +: 8]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.shift) begin
      col_q <= col_i;
    end
    if (ctl_i.calc) begin
      part_q <= part_d;
    end
  end

  assign col_o  = col_q;
  assign part_o = part_q;

endmodule

FILE: rtl/gb5_linebuf.sv
// ----------------------------------------------------------------------------
// gb5_linebuf
// Four line stores packed in one memory word per column, with a bypass for a
// read that meets a write to the same column.
// ----------------------------------------------------------------------------
module gb5_linebuf import gb5_pkg::*; #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  slot_row_t     wr_data_i,
  output slot_row_t     rd_data_o
);

  slot_row_t mem [DEPTH];
  slot_row_t rdata_q;
  slot_row_t fwd_q;
  logic      fwd_hit_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rdata_q <= mem[rd_addr_i];
      fwd_q   <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_hit_q <= 1'b0;
    end else if (rd_en_i) begin
      fwd_hit_q <= wr_en_i && (wr_addr_i == rd_addr_i);
    end
  end

  assign rd_data_o = fwd_hit_q ? fwd_q : rdata_q;

endmodule

FILE: rtl/gb5_div.sv
// ----------------------------------------------------------------------------
// gb5_div
// Adds the five column sums per channel, then divides by 273 through a
// reciprocal multiply.
// ----------------------------------------------------------------------------
module gb5_div import gb5_pkg::*; (
  input  logic      clk_i,
  input  div_ctl_t  ctl_i,
  input  part_row_t parts_i,
  output chan_t     quo_o
);

  logic [NCH-1:0][SUM_W-1:0]  sum_d;
  logic [NCH-1:0][SUM_W-1:0]  sum_q;
  logic [NCH-1:0][PROD_W-1:0] prod_q;

  always_comb begin
    sum_d = '0;
    for (int ch = 0; ch < NCH; ch++) begin
      for (int c = 0; c < NTAP; c++) begin
        sum_d[ch] = sum_d[ch] + SUM_W'(parts_i[c][ch]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld_sum) begin
      sum_q <= sum_d;
    end
    if (ctl_i.ld_prod) begin
      for (int ch = 0; ch < NCH; ch++) begin
        prod_q[ch] <= PROD_W'(sum_q[ch]) * PROD_W'(RECIP);
      end
    end
  end

  always_comb begin
    for (int ch = 0; ch < NCH; ch++) begin
      quo_o[ch] = prod_q[ch][RECIP_SHIFT +: 8];
    end
  end

endmodule

FILE: rtl/gaussian_blur_5x5_rgb.sv
// Path: each result goes through window cell, sum, product and output registers.
// Throughput: one pixel per cycle; the pipeline holds only while a result
//   word waits at a stalled output, set by one line store read and one write per pixel.
// Reset: counters clear, size registers return to 640 x 480, pipeline empties;
//   line store contents are not cleared.
// ----------------------------------------------------------------------------
// gaussian_blur_5x5_rgb
// 5x5 Gaussian blur of an RGB pixel stream in raster order, built from line
// stores and a row of five window column cells.
// ----------------------------------------------------------------------------
module gaussian_blur_5x5_rgb import gb5_pkg::*; #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,

  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  red_i,
  input  logic [7:0]  green_i,
  input  logic [7:0]  blue_i,
  input  logic        frame_start_i,

  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  blur_red_o,
  output logic [7:0]  blur_green_o,
  output logic [7:0]  blur_blue_o,
  output logic [10:0] center_col_o,
  output logic [11:0] center_row_o
);

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  logic [11:0] width_q;
  logic [11:0] height_q;
  logic [11:0] column_count_q, column_count_d;
  logic [11:0] row_count_q, row_count_d;

  logic        pipe_en;
  logic        accept;
  logic [11:0] col;
  logic [11:0] row;
  logic [12:0] col_nx;
  logic [12:0] row_nx;
  logic        col_wrap;
  logic        row_wrap;
  logic        emit;
  logic [AW-1:0] x;

  logic          s1_valid_q;
  logic          s1_emit_q;
  pix_t          s1_pix_q;
  logic [AW-1:0] s1_x_q;
  pos_t          s1_pos_q;
  logic          s2_valid_q, s3_valid_q, s4_valid_q, s5_valid_q;
  pos_t          s2_pos_q, s3_pos_q, s4_pos_q, s5_pos_q;

  slot_row_t lb_rd_data;
  pix_col_t  new_col;
  cell_ctl_t cell_ctl;
  div_ctl_t  div_ctl;
  pix_col_t  cell_col [NTAP];
  part_row_t part_row;
  chan_t     quo;

  logic       out_valid_q;
  chan_t      out_pix_q;
  pos_t       out_pos_q;

  // configuration
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        REG_WIDTH:  width_q  <= pwdata[11:0];
        REG_HEIGHT: height_q <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_WIDTH:  prdata = {20'd0, width_q};
      REG_HEIGHT: prdata = {20'd0, height_q};
      default:    prdata = '0;
    endcase
  end

  // position tracking
  assign pipe_en    = !(out_valid_q && out_stall_i);
  assign in_stall_o = !pipe_en;
  assign accept     = in_valid_i && pipe_en;

  assign col      = frame_start_i ? 12'd0 : column_count_q;
  assign row      = frame_start_i ? 12'd0 : row_count_q;
  assign col_nx   = 13'(col) + 13'd1;
  assign row_nx   = 13'(row) + 13'd1;
  assign col_wrap = (col_nx >= {1'b0, width_q}) || (32'(col_nx) >= MAX_WIDTH);
  assign row_wrap = row_nx >= {1'b0, height_q};
  assign emit     = (col >= 12'd5) && (row >= 12'd5)
                 && (col_nx < {1'b0, width_q}) && (row_nx < {1'b0, height_q});
  assign x        = AW'(col);

  always_comb begin
    column_count_d = col_wrap ? 12'd0 : col_nx[11:0];
    row_count_d    = row;
    if (col_wrap) begin
      row_count_d = row_wrap ? 12'd0 : row_nx[11:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_count_q <= '0;
      row_count_q    <= '0;
    end else if (accept) begin
      column_count_q <= column_count_d;
      row_count_q    <= row_count_d;
    end
  end

  // pipeline valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s1_emit_q   <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      s4_valid_q  <= 1'b0;
      s5_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (pipe_en) begin
      s1_valid_q  <= accept;
      s1_emit_q   <= accept && emit;
      s2_valid_q  <= s1_valid_q && s1_emit_q;
      s3_valid_q  <= s2_valid_q;
      s4_valid_q  <= s3_valid_q;
      s5_valid_q  <= s4_valid_q;
      out_valid_q <= s5_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pix_q      <= {blue_i, green_i, red_i};
      s1_x_q        <= x;
      s1_pos_q.ccol <= 11'(col - 12'd2);
      s1_pos_q.crow <= row - 12'd2;
    end
    if (pipe_en) begin
      s2_pos_q <= s1_pos_q;
      s3_pos_q <= s2_pos_q;
      s4_pos_q <= s3_pos_q;
      s5_pos_q <= s4_pos_q;
    end
    if (pipe_en && s5_valid_q) begin
      out_pix_q <= quo;
      out_pos_q <= s5_pos_q;
    end
  end

  // line stores
  assign new_col = {s1_pix_q, lb_rd_data};

  gb5_linebuf #(
    .DEPTH (MAX_WIDTH),
    .AW    (AW)
  ) u_linebuf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_addr_i (x),
    .wr_en_i   (pipe_en && s1_valid_q),
    .wr_addr_i (s1_x_q),
    .wr_data_i (new_col[NTAP-1:1]),
    .rd_data_o (lb_rd_data)
  );

  // window cells, rightmost takes the new column
  assign cell_ctl.shift = pipe_en && s1_valid_q;
  assign cell_ctl.calc  = pipe_en && s2_valid_q;

  for (genvar c = 0; c < NTAP; c++) begin : g_cell
    pix_col_t cin;
    part_t    cpart;
    if (c == NTAP - 1) begin : g_head
      assign cin = new_col;
    end else begin : g_link
      assign cin = cell_col[c+1];
    end
    gb5_cell #(
      .POS (c)
    ) u_cell (
      .clk_i  (clk_i),
      .ctl_i  (cell_ctl),
      .col_i  (cin),
      .col_o  (cell_col[c]),
      .part_o (cpart)
    );
    assign part_row[c] = cpart;
  end

  assign div_ctl.ld_sum  = pipe_en && s3_valid_q;
  assign div_ctl.ld_prod = pipe_en && s4_valid_q;

  gb5_div u_div (
    .clk_i   (clk_i),
    .ctl_i   (div_ctl),
    .parts_i (part_row),
    .quo_o   (quo)
  );

  // output word
  assign out_valid_o  = out_valid_q;
  assign blur_red_o   = out_pix_q[0];
  assign blur_green_o = out_pix_q[1];
  assign blur_blue_o  = out_pix_q[2];
  assign center_col_o = out_pos_q.ccol;
  assign center_row_o = out_pos_q.crow;

  a_center_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (center_col_o >= 11'd3 && center_row_o >= 12'd3))
    else $error("result centre too close to frame edge");

  a_col_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(column_count_q) < MAX_WIDTH)
    else $error("column counter beyond line store depth");

  a_frame_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && frame_start_i) |=> (column_count_q <= 12'd1 && row_count_q <= 12'd1))
    else $error("frame start did not restart position");

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 5x5 Gaussian blur of an RGB pixel stream.
// Frames are fed in raster order under random sender gaps and receiver
// stalls. A line store and window model predicts every blurred word, which
// is compared with the DUT output in order. Size registers are rewritten on
// the APB port between frames and read back.
// ----------------------------------------------------------------------------
module tb;
  import gb5_pkg::*;

  localparam int MAXW = 2048;
  localparam int KSUM = 273;
  localparam int SETTLE_CYC = 12;
  localparam int EXT_PIX = 84;
  // kernel weights, row-major; the list is symmetric end to end
  localparam logic [24:0][5:0] KERN = {
    6'd1, 6'd4,  6'd7,  6'd4,  6'd1,
    6'd4, 6'd16, 6'd26, 6'd16, 6'd4,
    6'd7, 6'd26, 6'd41, 6'd26, 6'd7,
    6'd4, 6'd16, 6'd26, 6'd16, 6'd4,
    6'd1, 6'd4,  6'd7,  6'd4,  6'd1
  };

  typedef enum logic [1:0] {PX_FILL, PX_SPOT, PX_RAND, PX_RAIL} px_e;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [10:0] ccol;
    logic [11:0] crow;
  } blur_word_t;

  typedef struct packed {
    logic [11:0] w;
    logic [11:0] h;
    logic [15:0] npix;
    px_e         sty;
    logic [23:0] rgb;
    logic        fix;
  } blur_case_t;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  red_i;
  logic [7:0]  green_i;
  logic [7:0]  blue_i;
  logic        frame_start_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [7:0]  blur_red_o;
  logic [7:0]  blur_green_o;
  logic [7:0]  blur_blue_o;
  logic [10:0] center_col_o;
  logic [11:0] center_row_o;

  gaussian_blur_5x5_rgb #(.MAX_WIDTH(MAXW)) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .red_i         (red_i),
    .green_i       (green_i),
    .blue_i        (blue_i),
    .frame_start_i (frame_start_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .blur_red_o    (blur_red_o),
    .blur_green_o  (blur_green_o),
    .blur_blue_o   (blur_blue_o),
    .center_col_o  (center_col_o),
    .center_row_o  (center_row_o)
  );

  // blur model state
  int unsigned cfg_w;
  int unsigned cfg_h;
  int unsigned col_cnt;
  int unsigned row_cnt;
  logic [23:0] lstore [4][MAXW];
  logic [23:0] win [5][5];
  logic        fix_on;
  logic [23:0] fix_rgb;
  blur_word_t  blur_due [$];

  int fed;
  int err_cnt;
  int tx_pct;
  int rx_pct;

  blur_case_t dir_cases [11];

  always #10 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < rx_pct);
  end

  task automatic flag_error(input string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("%s", msg);
  endtask

  function automatic logic [7:0] chan_blur(input int sh);
    int unsigned acc;
    acc = 0;
    for (int r = 0; r < 5; r++)
      for (int c = 0; c < 5; c++)
        acc += KERN[r*5+c] * win[r][c][sh +: 8];
    return 8'(acc / KSUM);
  endfunction

  task automatic blur_step(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                           input logic fs);
    int unsigned wd;
    int unsigned ht;
    int unsigned col;
    int unsigned row;
    int unsigned x;
    int unsigned cc;
    int unsigned cr;
    logic [23:0] vcol [5];
    blur_word_t  wexp;
    wd = (cfg_w > MAXW) ? MAXW : cfg_w;
    if (wd == 0) wd = 1;
    ht = (cfg_h == 0) ? 1 : cfg_h;
    col = fs ? 0 : col_cnt;
    row = fs ? 0 : row_cnt;
    x = col % MAXW;
    for (int k = 0; k < 4; k++) vcol[k] = lstore[k][x];
    vcol[4] = {b, g, r};
    for (int k = 0; k < 4; k++) lstore[k][x] = vcol[k+1];
    for (int i = 0; i < 5; i++) begin
      for (int j = 0; j < 4; j++) win[i][j] = win[i][j+1];
      win[i][4] = vcol[i];
    end
    if (col >= 5 && row >= 5) begin
      cc = col - 2;
      cr = row - 2;
      if (cc + 3 < cfg_w && cr + 3 < cfg_h) begin
        wexp.red   = fix_on ? fix_rgb[7:0]   : chan_blur(0);
        wexp.green = fix_on ? fix_rgb[15:8]  : chan_blur(8);
        wexp.blue  = fix_on ? fix_rgb[23:16] : chan_blur(16);
        wexp.ccol  = cc[10:0];
        wexp.crow  = cr[11:0];
        blur_due.push_back(wexp);
      end
    end
    col++;
    if (col >= wd) begin
      col = 0;
      row++;
      if (row >= ht) row = 0;
    end
    col_cnt = col & 12'hFFF;
    row_cnt = row & 12'hFFF;
  endtask

  always @(posedge clk_i) begin : mon
    blur_word_t got;
    blur_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {blur_red_o, blur_green_o, blur_blue_o, center_col_o, center_row_o};
      if (blur_due.size() == 0) begin
        flag_error($sformatf("unexpected word r=%0d g=%0d b=%0d col=%0d row=%0d",
                             got.red, got.green, got.blue, got.ccol, got.crow));
      end else begin
        want = blur_due.pop_front();
        if (got !== want)
          flag_error($sformatf({"mismatch: exp r=%0d g=%0d b=%0d col=%0d row=%0d",
                                " / got r=%0d g=%0d b=%0d col=%0d row=%0d"},
                               want.red, want.green, want.blue, want.ccol, want.crow,
                               got.red, got.green, got.blue, got.ccol, got.crow));
      end
    end
  end

  task automatic apb_xfer(input logic wr, input logic [2:0] addr, input logic [31:0] wdat,
                          output logic [31:0] rdat);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdat;
    @(negedge clk_i);
    penable <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (pready) break;
    end
    rdat = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic reg_check(input logic [2:0] addr, input logic [31:0] expv);
    logic [31:0] rd;
    apb_xfer(1'b0, addr, 32'h0, rd);
    if (rd !== expv)
      flag_error($sformatf("register at %0d: exp %0d got %0d", addr, expv, rd));
  endtask

  task automatic set_frame(input int w, input int h);
    logic [31:0] d;
    logic [31:0] rd;
    d = $urandom();
    d[11:0] = w[11:0];
    apb_xfer(1'b1, {REG_WIDTH, 2'b00}, d, rd);
    cfg_w = w & 12'hFFF;
    d = $urandom();
    d[11:0] = h[11:0];
    apb_xfer(1'b1, {REG_HEIGHT, 2'b00}, d, rd);
    cfg_h = h & 12'hFFF;
    reg_check({REG_WIDTH, 2'b00}, {20'h0, w[11:0]});
    reg_check({REG_HEIGHT, 2'b00}, {20'h0, h[11:0]});
  endtask

  task automatic put_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                           input logic fs);
    while ($urandom_range(99) < tx_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    red_i         <= r;
    green_i       <= g;
    blue_i        <= b;
    frame_start_i <= fs;
    forever begin
      @(posedge clk_i);
      if (!in_stall_o) break;
    end
    blur_step(r, g, b, fs);
    fed++;
    @(negedge clk_i);
  endtask

  task automatic feed_frame(input int wd, input int npix, input px_e sty,
                            input logic [23:0] base, input int brk, input logic fs0);
    logic [23:0] p;
    for (int i = 0; i < npix; i++) begin
      case (sty)
        PX_FILL: p = base;
        PX_SPOT: p = (i == 3*wd + 3) ? base : 24'h0;
        PX_RAIL: begin
          for (int ch = 0; ch < 3; ch++) begin
            case ($urandom_range(2))
              0:       p[8*ch +: 8] = 8'h00;
              1:       p[8*ch +: 8] = 8'hFF;
              default: p[8*ch +: 8] = 8'($urandom());
            endcase
          end
        end
        default: p = 24'($urandom());
      endcase
      put_pixel(p[7:0], p[15:8], p[23:16], (i == 0 && fs0) || i == brk);
    end
  endtask

  // drain: every expected word out, then a settling wait for pixels with no word
  task automatic settle();
    in_valid_i <= 1'b0;
    while (blur_due.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYC) @(negedge clk_i);
  endtask

  initial begin
    int w;
    int h;
    int n;
    int brk;
    int roll;
    int start;
    px_e sty;
    int ext_w [3];
    int ext_h [3];
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    in_valid_i    = 1'b0;
    red_i         = '0;
    green_i       = '0;
    blue_i        = '0;
    frame_start_i = 1'b0;
    out_stall_i   = 1'b0;
    cfg_w         = 640;
    cfg_h         = 480;
    col_cnt       = 0;
    row_cnt       = 0;
    fix_on        = 1'b0;
    fix_rgb       = '0;
    fed           = 0;
    err_cnt       = 0;
    tx_pct        = 6;
    rx_pct        = 61;
    for (int k = 0; k < 4; k++)
      for (int i = 0; i < MAXW; i++) lstore[k][i] = '0;
    for (int i = 0; i < 5; i++)
      for (int j = 0; j < 5; j++) win[i][j] = '0;
    ext_w = '{2048, 4095, 7};
    ext_h = '{7, 7, 4095};
    dir_cases = '{
      '{12'd7, 12'd7, 16'd41, PX_FILL, 24'h000000, 1'b1},
      '{12'd7, 12'd7, 16'd41, PX_FILL, 24'hFFFFFF, 1'b1},
      '{12'd7, 12'd7, 16'd41, PX_FILL, 24'hAA00FF, 1'b1},
      '{12'd7, 12'd7, 16'd41, PX_FILL, 24'h5AAA55, 1'b1},
      '{12'd7, 12'd7, 16'd49, PX_SPOT, 24'hFFFFFF, 1'b0},
      '{12'd7, 12'd7, 16'd98, PX_FILL, 24'hC04080, 1'b1},  // 2nd frame by row wrap
      '{12'd8, 12'd9, 16'd72, PX_RAIL, 24'h000000, 1'b0},
      '{12'd0, 12'd7, 16'd10, PX_FILL, 24'hFFFFFF, 1'b0},  // zero width
      '{12'd9, 12'd0, 16'd45, PX_RAND, 24'h000000, 1'b0},  // zero height
      '{12'd6, 12'd9, 16'd54, PX_RAND, 24'h000000, 1'b0},
      '{12'd9, 12'd6, 16'd54, PX_RAND, 24'h000000, 1'b0}
    };

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    reg_check({REG_WIDTH, 2'b00}, 32'(WIDTH_RST));
    reg_check({REG_HEIGHT, 2'b00}, 32'(HEIGHT_RST));

    foreach (dir_cases[i]) begin
      settle();
      set_frame(dir_cases[i].w, dir_cases[i].h);
      fix_on  = dir_cases[i].fix;
      fix_rgb = dir_cases[i].rgb;
      feed_frame(dir_cases[i].w, dir_cases[i].npix, dir_cases[i].sty, dir_cases[i].rgb,
                 -1, 1'b1);
      fix_on = 1'b0;
    end

    // width lowered in mid row: column counter wraps at its next advance
    settle();
    set_frame(20, 12);
    feed_frame(20, 5*20 + 13, PX_RAND, 24'h0, -1, 1'b1);
    settle();
    set_frame(10, 12);
    feed_frame(10, 60, PX_RAND, 24'h0, -1, 1'b0);

    for (int m = 0; m < 3; m++) begin
      case (m)
        0: begin tx_pct = 6;  rx_pct = 61; end
        1: begin tx_pct = 61; rx_pct = 6;  end
        default: begin tx_pct = 0; rx_pct = 0; end
      endcase
      start = fed;
      while (fed - start < 180) begin
        roll = $urandom_range(99);
        if (roll < 5) w = $urandom_range(6);
        else if (roll < 15) w = $urandom_range(80, 25);
        else w = $urandom_range(24, 7);
        h = ($urandom_range(99) < 10) ? $urandom_range(6) : $urandom_range(11, 7);
        n = ((w == 0) ? 1 : w) * ((h == 0) ? 1 : h);
        brk = -1;
        if (n > 1 && $urandom_range(99) < 10) brk = $urandom_range(n - 1, 1);
        if ($urandom_range(99) < 10) n = $urandom_range(n, 1);
        roll = $urandom_range(99);
        if (roll < 60) sty = PX_RAND;
        else if (roll < 85) sty = PX_RAIL;
        else if (roll < 95) sty = PX_FILL;
        else sty = PX_SPOT;
        settle();
        set_frame(w, h);
        feed_frame(w, n, sty, 24'($urandom()), brk, 1'b1);
      end
      settle();
      set_frame(ext_w[m], ext_h[m]);
      feed_frame(ext_w[m], EXT_PIX, PX_RAND, 24'h0, -1, 1'b1);
    end

    settle();
    if (err_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #12ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
